// ===== sv/itoa_pkg.sv =====
// Types, codes and character helpers shared by the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_HEXL = 3'd2;
    localparam logic [2:0] ACT_HEXU = 3'd3;
    localparam logic [2:0] ACT_PTR  = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        K_DEC = 2'd0,
        K_HEX = 2'd1,
        K_PTR = 2'd2,
        K_NIL = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_res;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic        upper;
        logic [63:0] mag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else if (upper) begin
            c = CH_UA + {4'd0, nib} - 8'd10;
        end else begin
            c = CH_LA + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] nil_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/itoa_front.sv =====
// Front end: accepts a command word, decodes the format and prepares the magnitude.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_front (
    input  logic            start,
    input  itoa_pkg::t_cmd  i_cmd,
    input  itoa_pkg::t_qstat i_qstat,
    output logic            o_push,
    output itoa_pkg::t_job  o_job
);
    import itoa_pkg::*;

    logic [31:0] low;
    logic        take;

    assign low  = i_cmd.value[31:0];
    assign take = start & ~i_qstat.full;

    always_comb begin
        o_push      = 1'b0;
        o_job.kind  = K_DEC;
        o_job.neg   = 1'b0;
        o_job.upper = 1'b0;
        o_job.mag   = {32'd0, low};
        case (i_cmd.action)
            ACT_SDEC: begin
                o_push    = take;
                o_job.neg = low[31];
                o_job.mag = {32'd0, low[31] ? (32'd0 - low) : low};
            end
            ACT_UDEC: begin
                o_push = take;
            end
            ACT_HEXL: begin
                o_push     = take;
                o_job.kind = K_HEX;
            end
            ACT_HEXU: begin
                o_push      = take;
                o_job.kind  = K_HEX;
                o_job.upper = 1'b1;
            end
            ACT_PTR: begin
                o_push     = take;
                o_job.kind = (i_cmd.value == 64'd0) ? K_NIL : K_PTR;
                o_job.mag  = i_cmd.value;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/itoa_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itoa_pkg::t_job   i_job,
    input  logic             i_pop,
    output itoa_pkg::t_job   o_job,
    output itoa_pkg::t_qstat o_qstat
);
    import itoa_pkg::*;

    localparam logic [Q_AW:0] DEPTH = (Q_AW + 1)'(Q_DEPTH);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_qstat.full  = (r_cnt == DEPTH);
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push & ~o_qstat.full;
    assign do_pop  = i_pop & ~o_qstat.empty;
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + {{Q_AW{1'b0}}, do_push} - {{Q_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== sv/itoa_back.sv =====
// Back end: binary to BCD conversion, leading zero skip and character output.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  itoa_pkg::t_job   i_job,
    input  itoa_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_strobe,
    output itoa_pkg::t_res   o_res
);
    import itoa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_SKIP = 6'b000100,
        S_PFX  = 6'b001000,
        S_DIG  = 6'b010000,
        S_NIL  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        P_NONE  = 2'd0,
        P_MINUS = 2'd1,
        P_HEX   = 2'd2
    } t_pfx;

    t_state      r_state, n_state;
    t_pfx        r_pfx, n_pfx;
    logic        r_upper, n_upper;
    logic [63:0] r_dig, n_dig;
    logic [39:0] r_bcd, n_bcd;
    logic [39:0] adj;
    logic [4:0]  r_cnt, n_cnt;
    logic [4:0]  r_left, n_left;
    logic [2:0]  r_idx, n_idx;
    logic        r_strobe, n_strobe;
    t_res        r_res, n_res;

    always_comb begin
        for (int d = 0; d < 10; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                      : r_bcd[d*4 +: 4];
        end
    end

    assign o_pop = (r_state == S_IDLE) & ~i_qstat.empty;

    always_comb begin
        n_state       = r_state;
        n_pfx         = r_pfx;
        n_upper       = r_upper;
        n_dig         = r_dig;
        n_bcd         = r_bcd;
        n_cnt         = r_cnt;
        n_left        = r_left;
        n_idx         = r_idx;
        n_strobe      = 1'b0;
        n_res.char_code = hex_char(r_dig[63:60], r_upper);
        n_res.last    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_upper = i_job.upper;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_bcd   = '0;
                    case (i_job.kind)
                        K_DEC: begin
                            n_dig   = {i_job.mag[31:0], 32'd0};
                            n_pfx   = i_job.neg ? P_MINUS : P_NONE;
                            n_state = S_CONV;
                        end
                        K_HEX: begin
                            n_dig   = {i_job.mag[31:0], 32'd0};
                            n_left  = 5'd8;
                            n_pfx   = P_NONE;
                            n_state = S_SKIP;
                        end
                        K_PTR: begin
                            n_dig   = i_job.mag;
                            n_left  = 5'd16;
                            n_pfx   = P_HEX;
                            n_state = S_SKIP;
                        end
                        default: begin
                            n_state = S_NIL;
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_bcd = {adj[38:0], r_dig[63]};
                n_dig = {r_dig[62:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_dig   = {adj[38:0], r_dig[63], 24'd0};
                    n_left  = 5'd10;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_dig[63:60] == 4'd0 && r_left != 5'd1) begin
                    n_dig  = {r_dig[59:0], 4'd0};
                    n_left = r_left - 5'd1;
                end else begin
                    n_state = (r_pfx == P_NONE) ? S_DIG : S_PFX;
                end
            end
            S_PFX: begin
                n_strobe = 1'b1;
                if (r_pfx == P_MINUS) begin
                    n_res.char_code = CH_MINUS;
                    n_state = S_DIG;
                end else if (r_idx == 3'd0) begin
                    n_res.char_code = CH_ZERO;
                    n_idx = 3'd1;
                end else begin
                    n_res.char_code = CH_X;
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                n_strobe   = 1'b1;
                n_res.last = (r_left == 5'd1);
                n_dig      = {r_dig[59:0], 4'd0};
                n_left     = r_left - 5'd1;
                if (r_left == 5'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_NIL: begin
                n_strobe        = 1'b1;
                n_res.char_code = nil_char(r_idx);
                n_res.last      = (r_idx == 3'd4);
                n_idx           = r_idx + 3'd1;
                if (r_idx == 3'd4) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx   <= n_pfx;
        r_upper <= n_upper;
        r_dig   <= n_dig;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_idx   <= n_idx;
        r_res   <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, job queue, back end.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.
`timescale 1ns / 1ps

// A command word (format and value) is taken when start is high and busy is low;
// up to two words queue ahead of the converter. Each character leaves on o_res
// for one cycle with o_strobe high, and the receiver must take it then. Decimal
// words pass through the shift-and-add-3 conversion loop, then suppressed leading
// zeros are skipped, a minus sign goes out if the value is negative, and the
// digits follow. Hex and pointer words skip the conversion; pointers get a "0x"
// prefix and a zero pointer prints "(nil)".
// Unused format codes are dropped with no output.
module integer_to_ascii_formatter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  itoa_pkg::t_cmd i_cmd,
    output logic           o_strobe,
    output itoa_pkg::t_res o_res
);
    import itoa_pkg::*;

    t_qstat qstat;
    t_job   push_job, pop_job;
    logic   push, pop;

    assign busy = qstat.full;

    itoa_front u_front (
        .start   (start),
        .i_cmd   (i_cmd),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    itoa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_qstat (qstat)
    );

    itoa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (pop_job),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// ===== dv/tb_integer_to_ascii_formatter.sv =====
// Self-checking testbench for integer_to_ascii_formatter: a directed table, then random words,
// each character checked against the expected text, taken from the table or from a predictor.
// Depends on itoa_pkg and integer_to_ascii_formatter.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

    import itoa_pkg::*;

    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam int    RANDOM_WORDS = 480;
    localparam int    TAIL_CYCLES  = 60;
    localparam int    REPORT_LIMIT = 10;
    localparam string PREDICTED    = "*";
    localparam string NIL_TEXT     = "(nil)";

    typedef logic [7:0] t_text [$];

    typedef struct {
        logic [2:0]  action;
        logic [63:0] value;
        string       text;
    } t_row;

    localparam int DIR_ROWS = 23;

    t_row dir_rows [DIR_ROWS] = '{
        '{ACT_SDEC,  64'h0000_0000_0000_0000, "0"},
        '{ACT_SDEC,  64'h0000_0000_8000_0000, "-2147483648"},
        '{ACT_SDEC,  64'h0000_0000_7fff_ffff, "2147483647"},
        '{ACT_SDEC,  64'h0000_0000_ffff_ffff, "-1"},
        '{ACT_SDEC,  64'hffff_ffff_0000_0005, "5"},
        '{ACT_UDEC,  64'h0000_0000_0000_0000, "0"},
        '{ACT_UDEC,  64'h0000_0000_ffff_ffff, "4294967295"},
        '{ACT_UDEC,  64'h1234_5678_8000_0000, PREDICTED},
        '{ACT_UDEC,  64'h0000_0000_3b9a_ca00, PREDICTED},
        '{ACT_HEXL,  64'h0000_0000_0000_0000, "0"},
        '{ACT_HEXL,  64'h0000_0000_ffff_ffff, "ffffffff"},
        '{ACT_HEXL,  64'hdead_beef_0000_abcd, "abcd"},
        '{ACT_HEXU,  64'hffff_ffff_ffff_ffff, "FFFFFFFF"},
        '{ACT_HEXU,  64'h0123_4567_89ab_cdef, "89ABCDEF"},
        '{ACT_HEXU,  64'h0000_0000_0000_000a, "A"},
        '{ACT_PTR,   64'h0000_0000_0000_0000, "(nil)"},
        '{ACT_PTR,   64'h0000_0000_0000_0001, "0x1"},
        '{ACT_PTR,   64'hffff_ffff_ffff_ffff, "0xffffffffffffffff"},
        '{ACT_PTR,   64'h8000_0000_0000_0000, "0x8000000000000000"},
        '{ACT_PTR,   64'h0000_0001_0000_0000, PREDICTED},
        '{ACT_RSVD5, 64'h0000_0000_0000_0007, ""},
        '{ACT_RSVD6, 64'hffff_ffff_ffff_ffff, ""},
        '{ACT_RSVD7, 64'h0000_0000_8000_0000, ""}
    };

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    t_cmd   i_cmd   = '0;
    logic   busy;
    logic   o_strobe;
    t_res   o_res;

    t_res   pending_chars [$];
    int     mismatch_count = 0;
    int     burst_left     = 0;

    integer_to_ascii_formatter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_text render_text(input t_cmd c);
        t_text       txt;
        t_text       digs;
        logic [31:0] low;
        logic [63:0] v;
        logic [7:0]  alpha;
        logic [3:0]  nib;
        bit          is_hex;
        low    = c.value[31:0];
        v      = {32'd0, low};
        alpha  = (c.action == ACT_HEXU) ? CH_UA : CH_LA;
        is_hex = 1'b0;
        case (c.action)
            ACT_SDEC, ACT_UDEC: begin
                if (c.action == ACT_SDEC && low[31]) begin
                    txt.push_back(CH_MINUS);
                    low = -low;
                end
                do begin
                    digs.push_front(CH_ZERO + 8'(low % 32'd10));
                    low = low / 32'd10;
                end while (low != 32'd0);
            end
            ACT_HEXL, ACT_HEXU: begin
                is_hex = 1'b1;
            end
            ACT_PTR: begin
                if (c.value == 64'd0) begin
                    for (int k = 0; k < NIL_TEXT.len(); k++) txt.push_back(NIL_TEXT[k]);
                end else begin
                    txt.push_back(CH_ZERO);
                    txt.push_back(CH_X);
                    v      = c.value;
                    is_hex = 1'b1;
                end
            end
            default: ;
        endcase
        if (is_hex) begin
            do begin
                nib = v[3:0];
                digs.push_front((nib < 4'd10) ? CH_ZERO + {4'd0, nib}
                                              : alpha + {4'd0, nib} - 8'd10);
                v = v >> 4;
            end while (v != 64'd0);
        end
        foreach (digs[i]) txt.push_back(digs[i]);
        return txt;
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       ;
            1:       r = r >> $urandom_range(0, 63);
            2:       r[31:0] = 32'($urandom_range(0, 20));
            3:       r[31:0] = -32'($urandom_range(1, 20));
            4:       r = 64'($urandom_range(0, 3));
            default: r = 64'd1 << $urandom_range(0, 63);
        endcase
        return r;
    endfunction

    // Hold the word until taken, then queue its characters.
    task automatic send_word(input t_cmd c, input t_text want);
        bit   taken;
        t_res r;
        start <= 1'b1;
        i_cmd <= c;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        foreach (want[k]) begin
            r.char_code = want[k];
            r.last      = (k == want.size() - 1);
            pending_chars.push_back(r);
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endtask

    always @(negedge i_clk) begin : char_monitor
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                        o_res.char_code, o_res.last));
            end else begin
                want = pending_chars.pop_front();
                if (o_res.char_code !== want.char_code || o_res.last !== want.last) begin
                    note_mismatch($sformatf("char 0x%02h last %0b, expected 0x%02h last %0b",
                                            o_res.char_code, o_res.last,
                                            want.char_code, want.last));
                end
            end
        end
    end

    initial begin
        t_cmd  c;
        t_text want;
        int    sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            c.action = dir_rows[i].action;
            c.value  = dir_rows[i].value;
            want.delete();
            if (dir_rows[i].text == PREDICTED) begin
                want = render_text(c);
            end else begin
                for (int k = 0; k < dir_rows[i].text.len(); k++) begin
                    want.push_back(dir_rows[i].text[k]);
                end
            end
            send_word(c, want);
            pace();
        end
        drain();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 19) == 0) begin
                c.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
            end else begin
                c.action = 3'($urandom_range(ACT_SDEC, ACT_PTR));
                sent++;
            end
            c.value = pick_value();
            send_word(c, render_text(c));
            if (sent == RANDOM_WORDS / 2) begin
                drain();
            end else begin
                pace();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
